/* rtl/yrgbe_pkg.sv */
// shared types, constants and chroma code tables for the yuv420 to rgb block
// depends on nothing; imported by every module of the block
package yrgbe_pkg;

    localparam int MAX_WIDTH_DEF = 512;
    localparam int LW_BITS       = 10;
    localparam logic [LW_BITS-1:0] LW_RESET = 10'd512;
    localparam int ACC_BITS      = 42;
    localparam int FIFO_DEPTH    = 4;

    // q12 coefficients, rounded
    localparam logic signed [35:0] K_RV = 36'sd4669;
    localparam logic signed [35:0] K_GU = -36'sd1618;
    localparam logic signed [35:0] K_GV = -36'sd2380;
    localparam logic signed [35:0] K_BU = 36'sd8323;

    typedef logic [255:0][19:0] t_u_tab;
    typedef logic [255:0][20:0] t_v_tab;

    // one pixel handed from front to back
    typedef struct packed {
        logic [7:0]  luma;
        logic [15:0] chroma;    // u code in the upper byte, v code in the lower
        logic [7:0]  orig_red;
        logic [7:0]  orig_green;
        logic [7:0]  orig_blue;
        logic        kept;
        logic        frame_end;
    } t_item;

    // u code 0..255 to q12 in -111..111
    function automatic t_u_tab build_u_tab();
        t_u_tab tab;
        int     n;
        for (int i = 0; i < 256; i++) begin
            n = (i * 222 * 4096 + 127) / 255 - 111 * 4096;
            tab[i] = 20'(n);
        end
        return tab;
    endfunction

    // v code 0..255 to q12 in -157..157
    function automatic t_v_tab build_v_tab();
        t_v_tab tab;
        int     n;
        for (int i = 0; i < 256; i++) begin
            n = (i * 314 * 4096 + 127) / 255 - 157 * 4096;
            tab[i] = 21'(n);
        end
        return tab;
    endfunction

    localparam t_u_tab U_TAB = build_u_tab();
    localparam t_v_tab V_TAB = build_v_tab();

endpackage

/* rtl/yrgbe_front.sv */
// front end: row/column tracking, 4:2:0 chroma selection and the half-line store
// depends on yrgbe_pkg
module yrgbe_front import yrgbe_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [LW_BITS-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_luma,
    input  logic [7:0]         i_u_code,
    input  logic [7:0]         i_v_code,
    input  logic [7:0]         i_orig_red,
    input  logic [7:0]         i_orig_green,
    input  logic [7:0]         i_orig_blue,
    input  logic               i_frame_end,
    output logic               o_push_valid,
    input  logic               i_push_ready,
    output t_item              o_push_item
);

    localparam int HALF  = MAX_WIDTH / 2;
    localparam int COLW  = $clog2(MAX_WIDTH);
    localparam int SLOTW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CW0   = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (CW0 > LW_BITS) ? CW0 : LW_BITS;
    localparam logic [CW-1:0] TOP = CW'(MAX_WIDTH - (MAX_WIDTH % 2));
    localparam logic [CW-1:0] MIN_W = CW'(2);

    logic [LW_BITS-1:0] r_lw;
    logic [COLW-1:0]    r_col, n_col;
    logic               r_odd, n_odd;
    logic [15:0]        r_held;
    logic [15:0]        r_line [HALF];
    logic [15:0]        r_rdata;
    logic               r_s1_valid;
    logic               r_s1_use_mem;
    t_item              r_s1_item;

    logic               in_fire;
    logic               push;
    logic [CW-1:0]      w_raw;
    logic [CW-1:0]      width;
    logic [CW-1:0]      col_inc;
    logic [SLOTW-1:0]   slot;
    logic [15:0]        codes;
    logic               keep;

    assign o_in_ready = !r_s1_valid || i_push_ready;
    assign in_fire    = i_in_valid && o_in_ready;
    assign push       = r_s1_valid && i_push_ready;

    assign codes = {i_u_code, i_v_code};
    assign slot  = SLOTW'(r_col >> 1);
    assign keep  = !r_odd && !r_col[0];

    always_comb begin
        w_raw = CW'({r_lw[LW_BITS-1:1], 1'b0});
        if (w_raw < MIN_W) begin
            width = MIN_W;
        end else if (w_raw > TOP) begin
            width = TOP;
        end else begin
            width = w_raw;
        end
    end

    assign col_inc = CW'(r_col) + CW'(1);

    always_comb begin
        n_col = r_col;
        n_odd = r_odd;
        if (in_fire) begin
            if (i_frame_end) begin
                n_col = '0;
                n_odd = 1'b0;
            end else if (col_inc >= width) begin
                // end of row, also when the width was lowered mid-row
                n_col = '0;
                n_odd = !r_odd;
            end else begin
                n_col = COLW'(col_inc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lw       <= LW_RESET;
            r_col      <= '0;
            r_odd      <= 1'b0;
            r_held     <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lw <= i_cfg_wdata;
            end
            r_col <= n_col;
            r_odd <= n_odd;
            if (in_fire && keep) begin
                r_held <= codes;
            end
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // half-line store: written on even rows, read by the odd row below
    always_ff @(posedge i_clk) begin
        if (in_fire && keep) begin
            r_line[slot] <= codes;
        end
        if (in_fire) begin
            r_rdata <= r_line[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_use_mem          <= r_odd;
            r_s1_item.luma        <= i_luma;
            r_s1_item.chroma      <= keep ? codes : r_held;
            r_s1_item.orig_red    <= i_orig_red;
            r_s1_item.orig_green  <= i_orig_green;
            r_s1_item.orig_blue   <= i_orig_blue;
            r_s1_item.kept        <= keep;
            r_s1_item.frame_end   <= i_frame_end;
        end
    end

    always_comb begin
        o_push_item = r_s1_item;
        if (r_s1_use_mem) begin
            o_push_item.chroma = r_rdata;
        end
    end

    assign o_push_valid = r_s1_valid;

endmodule

/* rtl/yrgbe_fifo.sv */
// short queue between the front end and the conversion pipeline
// depends on yrgbe_pkg
module yrgbe_fifo import yrgbe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_push_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_pop_item
);

    localparam int PW = $clog2(FIFO_DEPTH);

    t_item           r_mem [FIFO_DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [PW:0]     r_cnt;
    logic            push, pop;

    assign o_push_ready = (r_cnt != (PW+1)'(FIFO_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + (PW+1)'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - (PW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_push_item;
        end
    end

endmodule

/* rtl/yrgbe_back.sv */
// back end: color matrix, clamp, squared error and per-frame accumulation
// depends on yrgbe_pkg
module yrgbe_back import yrgbe_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_pop_valid,
    output logic                o_pop_ready,
    input  t_item               i_pop_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_chroma_kept,
    output logic [ACC_BITS-1:0] o_error_sum,
    output logic                o_frame_done
);

    logic                 en;
    logic                 r_v1, r_v2, r_v3, r_v4, r_ov;
    t_item                r_i1, r_i2, r_i3, r_i4;
    logic signed [19:0]   r_uq;
    logic signed [20:0]   r_vq;
    logic signed [35:0]   r_p_rv, r_p_gu, r_p_gv, r_p_bu;
    logic [7:0]           r_r3, r_g3, r_b3;
    logic [7:0]           r_r4, r_g4, r_b4;
    logic [15:0]          r_er, r_eg, r_eb;
    logic [ACC_BITS-1:0]  r_acc;
    logic [ACC_BITS-1:0]  n_sum;
    logic signed [35:0]   uq_x, vq_x;

    // y*2^24 + chroma part, negative gives 0, otherwise truncate and saturate
    function automatic logic [7:0] to_channel(logic [7:0] y, logic signed [35:0] part);
        logic signed [35:0] t;
        t = $signed({4'b0, y, 24'b0}) + part;
        if (t[35]) begin
            return 8'd0;
        end else if (t[34:32] != 3'b0) begin
            return 8'd255;
        end else begin
            return t[31:24];
        end
    endfunction

    function automatic logic [15:0] sq_err(logic [7:0] a, logic [7:0] b);
        logic [15:0] d;
        d = {8'b0, (a > b) ? (a - b) : (b - a)};
        return d * d;
    endfunction

    // whole pipeline moves together when the output register can take a beat
    assign en          = !r_ov || i_out_ready;
    assign o_pop_ready = en;

    assign uq_x  = 36'(r_uq);
    assign vq_x  = 36'(r_vq);
    assign n_sum = r_acc + ACC_BITS'(r_er) + ACC_BITS'(r_eg) + ACC_BITS'(r_eb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_ov  <= 1'b0;
            r_acc <= '0;
        end else if (en) begin
            r_v1 <= i_pop_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4;
            if (r_v4) begin
                r_acc <= r_i4.frame_end ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // code to q12 lookup
            r_i1 <= i_pop_item;
            r_uq <= $signed(U_TAB[i_pop_item.chroma[15:8]]);
            r_vq <= $signed(V_TAB[i_pop_item.chroma[7:0]]);
            // products
            r_i2   <= r_i1;
            r_p_rv <= K_RV * vq_x;
            r_p_gu <= K_GU * uq_x;
            r_p_gv <= K_GV * vq_x;
            r_p_bu <= K_BU * uq_x;
            // sums and clamp
            r_i3 <= r_i2;
            r_r3 <= to_channel(r_i2.luma, r_p_rv);
            r_g3 <= to_channel(r_i2.luma, r_p_gu + r_p_gv);
            r_b3 <= to_channel(r_i2.luma, r_p_bu);
            // squared errors
            r_i4 <= r_i3;
            r_r4 <= r_r3;
            r_g4 <= r_g3;
            r_b4 <= r_b3;
            r_er <= sq_err(r_i3.orig_red, r_r3);
            r_eg <= sq_err(r_i3.orig_green, r_g3);
            r_eb <= sq_err(r_i3.orig_blue, r_b3);
            // output register
            o_red         <= r_r4;
            o_green       <= r_g4;
            o_blue        <= r_b4;
            o_chroma_kept <= r_i4.kept;
            o_frame_done  <= r_i4.frame_end;
            o_error_sum   <= n_sum;
        end
    end

    assign o_out_valid = r_ov;

endmodule

/* rtl/yuv420_to_rgb_with_error_top.sv */
// yuv 4:2:0 to rgb reconstruction with a per-frame squared-error sum. One pixel
// is taken per clock and one result leaves per clock, sustained while the output
// is not stalled; a pixel passes the front stage register, the queue and the five
// back-end stages before its result is valid. The rate is set by the front end's
// single read and at most one write of the half-line chroma store per pixel and
// by the five-stage conversion pipeline, which moves as a whole when its output
// register is free. A four-entry queue lets the input keep running for a few
// beats while the output stalls. The chroma store has no clearing pass; an odd
// row reading a slot no even row wrote (for example after widening the line
// mid-frame) returns arbitrary chroma. The user must write line_width only while
// the block is idle; the block itself does not enforce this.
// depends on yrgbe_pkg, yrgbe_front, yrgbe_fifo, yrgbe_back
module yuv420_to_rgb_with_error_top import yrgbe_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [LW_BITS-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_luma,
    input  logic [7:0]          i_u_code,
    input  logic [7:0]          i_v_code,
    input  logic [7:0]          i_orig_red,
    input  logic [7:0]          i_orig_green,
    input  logic [7:0]          i_orig_blue,
    input  logic                i_frame_end,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic                o_chroma_kept,
    output logic [ACC_BITS-1:0] o_error_sum,
    output logic                o_frame_done
);

    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    t_item push_item, pop_item;

    yrgbe_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_luma       (i_luma),
        .i_u_code     (i_u_code),
        .i_v_code     (i_v_code),
        .i_orig_red   (i_orig_red),
        .i_orig_green (i_orig_green),
        .i_orig_blue  (i_orig_blue),
        .i_frame_end  (i_frame_end),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    yrgbe_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    yrgbe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_item    (pop_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_chroma_kept (o_chroma_kept),
        .o_error_sum   (o_error_sum),
        .o_frame_done  (o_frame_done)
    );

endmodule
